### rtl/core/elg_pkg.sv
`default_nettype none

package elg_pkg;

  // Default modulus width and the fixed width of the stream fields.
  localparam int unsigned PRIME_BITS_DEF = 31;
  localparam int unsigned FIELD_W        = 31;
  localparam int unsigned IDX_W          = $clog2(FIELD_W);

  // Reset values of the configuration registers.
  localparam logic [31:0] PRIME_RESET      = 32'd2147483647;
  localparam logic [31:0] GENERATOR_RESET  = 32'd7;
  localparam logic [31:0] PUBLIC_KEY_RESET = 32'd1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PRIME      = 2'd0,
    REG_GENERATOR  = 2'd1,
    REG_PUBLIC_KEY = 2'd2
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_NEXT,
    ST_MACC,
    ST_MSQ,
    ST_SRED,
    ST_MEL,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### rtl/core/elg_mulmod.sv
`default_nettype none

// Bit-serial interleaved modular multiplier: res = a * b mod m.
// Requires a < m; b may be any value of SW bits. One bit of b per cycle, MSB first.
module elg_mulmod #(
  parameter int unsigned PB = 31,
  parameter int unsigned SW = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [PB-1:0] a_i,
  input  wire logic [SW-1:0] b_i,
  input  wire logic [PB-1:0] m_i,
  output logic               done_o,
  output logic [PB-1:0]      res_o
);

  localparam int unsigned CW = $clog2(SW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PB-1:0] a_q, a_d;
  logic [PB-1:0] m_q, m_d;
  logic [PB-1:0] acc_q, acc_d;
  logic [SW-1:0] b_q, b_d;

  logic [PB+1:0] sum;
  logic [PB+1:0] m_one;
  logic [PB+1:0] m_two;
  logic [PB+1:0] red;

  // Double the accumulator, add a when the current bit of b is set, then
  // bring the sum (below 3m) back under m with parallel compares.
  always_comb begin
    sum   = {1'b0, acc_q, 1'b0} + (b_q[SW-1] ? {2'b00, a_q} : '0);
    m_one = {2'b00, m_q};
    m_two = {1'b0, m_q, 1'b0};
    if (sum >= m_two) begin
      red = sum - m_two;
    end else if (sum >= m_one) begin
      red = sum - m_one;
    end else begin
      red = sum;
    end
  end

  // Step control.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    m_d    = m_q;
    acc_d  = acc_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(SW - 1);
      a_d    = a_i;
      m_d    = m_i;
      acc_d  = '0;
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = PB'(red);
      b_d   = {b_q[SW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

`default_nettype wire

### rtl/core/elg_seq.sv
`default_nettype none

// Sequencer: runs both exponentiations for a message start and the element
// multiply on the shared bit-serial multiplier, and holds the output register.
module elg_seq #(
  parameter int unsigned PB = 31
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [PB-1:0]          prime_i,
  input  wire logic [PB-1:0]          generator_i,
  input  wire logic [PB-1:0]          public_key_i,
  input  wire logic                   prime_wr_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   in_first_i,
  input  wire logic [elg_pkg::FIELD_W-1:0] in_key_i,
  input  wire logic [elg_pkg::FIELD_W-1:0] in_elem_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [elg_pkg::FIELD_W-1:0] out_c1_o,
  output logic [elg_pkg::FIELD_W-1:0] out_c2_o
);

  import elg_pkg::*;

  localparam int unsigned SW = (PB > FIELD_W) ? PB : FIELD_W;
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(FIELD_W - 1);

  state_e state_q, state_d;

  logic               phase_q, phase_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [FIELD_W-1:0] key_q, key_d;
  logic [FIELD_W-1:0] elem_q, elem_d;
  logic [PB-1:0]      acc_q, acc_d;
  logic [PB-1:0]      sq_q, sq_d;
  logic [FIELD_W-1:0] ss_q, ss_d;
  logic [FIELD_W-1:0] ssr_q, ssr_d;
  logic               ssr_ok_q, ssr_ok_d;
  logic [FIELD_W-1:0] c1_q, c1_d;
  logic [FIELD_W-1:0] c2_q, c2_d;
  logic               ov_q, ov_d;
  logic [FIELD_W-1:0] oc1_q, oc1_d;
  logic [FIELD_W-1:0] oc2_q, oc2_d;

  logic          mul_start;
  logic [PB-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic          mul_done;
  logic [PB-1:0] mul_res;
  logic          degen;
  logic          accept;

  assign degen  = (prime_i < PB'(2));
  assign accept = in_valid_i && (state_q == ST_IDLE);

  elg_mulmod #(
    .PB (PB),
    .SW (SW)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (prime_i),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Next state, multiplier launches and datapath updates.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    key_d     = key_q;
    elem_d    = elem_q;
    acc_d     = acc_q;
    sq_d      = sq_q;
    ss_d      = ss_q;
    ssr_d     = ssr_q;
    ssr_ok_d  = ssr_ok_q;
    c1_d      = c1_q;
    c2_d      = c2_q;
    ov_d      = ov_q;
    oc1_d     = oc1_q;
    oc2_d     = oc2_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;

    // The output register drains independently of the sequencer.
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    // A new modulus invalidates the cached reduced secret.
    if (prime_wr_i) begin
      ssr_ok_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d  = in_key_i;
          elem_d = in_elem_i;
          if (degen) begin
            // Every modular result is zero for a modulus below two.
            if (in_first_i) begin
              ss_d     = '0;
              ssr_d    = '0;
              ssr_ok_d = 1'b1;
              c1_d     = '0;
            end
            c2_d    = '0;
            state_d = ST_OUT;
          end else if (in_first_i) begin
            // Reduce the public key before the first exponentiation.
            phase_d   = 1'b0;
            mul_start = 1'b1;
            mul_a     = PB'(1);
            mul_b     = SW'(public_key_i);
            state_d   = ST_RED;
          end else if (ssr_ok_q) begin
            mul_start = 1'b1;
            mul_a     = PB'(ssr_q);
            mul_b     = SW'(in_elem_i);
            state_d   = ST_MEL;
          end else begin
            mul_start = 1'b1;
            mul_a     = PB'(1);
            mul_b     = SW'(ss_q);
            state_d   = ST_SRED;
          end
        end
      end

      ST_RED: begin
        if (mul_done) begin
          sq_d    = mul_res;
          acc_d   = PB'(1);
          idx_d   = '0;
          state_d = ST_NEXT;
        end
      end

      ST_NEXT: begin
        if (key_q[idx_q]) begin
          mul_start = 1'b1;
          mul_a     = acc_q;
          mul_b     = SW'(sq_q);
          state_d   = ST_MACC;
        end else if (idx_q != LAST_BIT) begin
          mul_start = 1'b1;
          mul_a     = sq_q;
          mul_b     = SW'(sq_q);
          state_d   = ST_MSQ;
        end else if (!phase_q) begin
          // Shared secret done; start on c1 with the generator.
          ss_d      = FIELD_W'(acc_q);
          phase_d   = 1'b1;
          mul_start = 1'b1;
          mul_a     = PB'(1);
          mul_b     = SW'(generator_i);
          state_d   = ST_RED;
        end else begin
          c1_d      = FIELD_W'(acc_q);
          ssr_d     = ss_q;
          ssr_ok_d  = 1'b1;
          mul_start = 1'b1;
          mul_a     = PB'(ss_q);
          mul_b     = SW'(elem_q);
          state_d   = ST_MEL;
        end
      end

      ST_MACC: begin
        if (mul_done) begin
          acc_d = mul_res;
          if (idx_q != LAST_BIT) begin
            mul_start = 1'b1;
            mul_a     = sq_q;
            mul_b     = SW'(sq_q);
            state_d   = ST_MSQ;
          end else if (!phase_q) begin
            ss_d      = FIELD_W'(mul_res);
            phase_d   = 1'b1;
            mul_start = 1'b1;
            mul_a     = PB'(1);
            mul_b     = SW'(generator_i);
            state_d   = ST_RED;
          end else begin
            c1_d      = FIELD_W'(mul_res);
            ssr_d     = ss_q;
            ssr_ok_d  = 1'b1;
            mul_start = 1'b1;
            mul_a     = PB'(ss_q);
            mul_b     = SW'(elem_q);
            state_d   = ST_MEL;
          end
        end
      end

      ST_MSQ: begin
        if (mul_done) begin
          sq_d    = mul_res;
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_NEXT;
        end
      end

      ST_SRED: begin
        if (mul_done) begin
          ssr_d     = FIELD_W'(mul_res);
          ssr_ok_d  = 1'b1;
          mul_start = 1'b1;
          mul_a     = mul_res;
          mul_b     = SW'(elem_q);
          state_d   = ST_MEL;
        end
      end

      ST_MEL: begin
        if (mul_done) begin
          c2_d    = FIELD_W'(mul_res);
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          oc1_d   = c1_q;
          oc2_d   = c2_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ov_q     <= 1'b0;
      ss_q     <= '0;
      ssr_q    <= '0;
      ssr_ok_q <= 1'b1;
      c1_q     <= '0;
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
      ss_q     <= ss_d;
      ssr_q    <= ssr_d;
      ssr_ok_q <= ssr_ok_d;
      c1_q     <= c1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    idx_q   <= idx_d;
    key_q   <= key_d;
    elem_q  <= elem_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    c2_q    <= c2_d;
    oc1_q   <= oc1_d;
    oc2_q   <= oc2_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_c1_o    = oc1_q;
  assign out_c2_o    = oc2_q;

endmodule

`default_nettype wire

### rtl/core/elg_mod.sv
`default_nettype none

// Configuration register file: prime, generator and public key, each held in
// the low PRIME_BITS bits; writes to unknown indexes are dropped.
module elg_mod #(
  parameter int unsigned PB = 31
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire logic [1:0]    index_i,
  input  wire logic [PB-1:0] data_i,
  output logic [PB-1:0]      prime_o,
  output logic [PB-1:0]      generator_o,
  output logic [PB-1:0]      public_key_o,
  output logic               prime_wr_o
);

  import elg_pkg::*;

  logic [PB-1:0] prime_q, prime_d;
  logic [PB-1:0] gen_q, gen_d;
  logic [PB-1:0] pub_q, pub_d;
  logic          pwr;

  // Register decode.
  always_comb begin
    prime_d = prime_q;
    gen_d   = gen_q;
    pub_d   = pub_q;
    pwr     = 1'b0;
    if (wr_i) begin
      unique case (index_i)
        REG_PRIME: begin
          prime_d = data_i;
          pwr     = 1'b1;
        end
        REG_GENERATOR: begin
          gen_d = data_i;
        end
        REG_PUBLIC_KEY: begin
          pub_d = data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= PB'(PRIME_RESET);
      gen_q   <= PB'(GENERATOR_RESET);
      pub_q   <= PB'(PUBLIC_KEY_RESET);
    end else begin
      prime_q <= prime_d;
      gen_q   <= gen_d;
      pub_q   <= pub_d;
    end
  end

  assign prime_o      = prime_q;
  assign generator_o  = gen_q;
  assign public_key_o = pub_q;
  assign prime_wr_o   = pwr;

endmodule

`default_nettype wire

### rtl/core/elgamal_stream_encryptor.sv
`default_nettype none

// ElGamal stream encryptor over a prime field of up to PRIME_BITS bits. Each
// input transaction yields exactly one output transaction carrying c1 of the
// current message and c2 = element * shared secret mod prime. A transaction
// with tuser (first) set starts a message: the shared secret public_key^k and
// c1 = generator^k are computed by square-and-multiply over the 31 key bits.
// All arithmetic runs on one bit-serial modular multiplier whose second
// operand is SW bits wide, SW being the larger of PRIME_BITS and 31. The first
// element transaction after the prime is rewritten first reduces the shared
// secret again; a message start adds two base reductions and between 30 and
// 61 products per exponentiation. One transaction is worked on at a time; the
// next is taken while the previous result still waits in the output register.
// A modulus below two makes every modular result zero.
module elgamal_stream_encryptor #(
  parameter int unsigned PRIME_BITS = elg_pkg::PRIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [PRIME_BITS-1:0] cfg_data_i,
  // Input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [63:0]           s_axis_tdata,  // ephemeral_key[30:0], message_element[61:31]
  input  wire logic                  s_axis_tuser,  // first
  // Output stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [63:0]                m_axis_tdata   // cipher_one[30:0], cipher_two[61:31]
);

  import elg_pkg::*;

  logic [PRIME_BITS-1:0] prime;
  logic [PRIME_BITS-1:0] generator;
  logic [PRIME_BITS-1:0] public_key;
  logic                  prime_wr;
  logic [FIELD_W-1:0]    c1;
  logic [FIELD_W-1:0]    c2;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  elg_mod #(
    .PB (PRIME_BITS)
  ) u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (cfg_valid_i),
    .index_i      (cfg_index_i),
    .data_i       (cfg_data_i),
    .prime_o      (prime),
    .generator_o  (generator),
    .public_key_o (public_key),
    .prime_wr_o   (prime_wr)
  );

  elg_seq #(
    .PB (PRIME_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prime_i      (prime),
    .generator_i  (generator),
    .public_key_i (public_key),
    .prime_wr_i   (prime_wr),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_first_i   (s_axis_tuser),
    .in_key_i     (s_axis_tdata[FIELD_W-1:0]),
    .in_elem_i    (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_c1_o     (c1),
    .out_c2_o     (c2)
  );

  assign m_axis_tdata = {2'b00, c2, c1};

endmodule

`default_nettype wire
